FILE: hdl/rbq_pkg.sv
// ----------------------------------------------------------------------------
// rbq_pkg
// Shared constants and types for the rotated box to ordered quad unit.
// ----------------------------------------------------------------------------
package rbq_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int CORDIC_STAGES   = 16;
    localparam int CORDIC_LAT      = CORDIC_STAGES + 2;

    localparam int IN_W   = 16;
    localparam int CS_W   = 34;
    localparam int ANG_W  = 32;
    localparam int PROD_W = 51;
    localparam int ACC_W  = 52;
    localparam int PIX_W  = 12;
    localparam int PIX_SHIFT = 31 + COORD_FRAC_BITS;

    localparam int SQRT_IN_W   = 42;
    localparam int SQRT_OUT_W  = 21;
    localparam int DIST_SUM_W  = SQRT_OUT_W + 2;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(652032874);
    localparam logic signed [PIX_W-1:0] PIX_MIN = -12'sd2048;
    localparam logic signed [PIX_W-1:0] PIX_MAX = 12'sd2047;

    localparam logic signed [ANG_W-1:0] ATAN_TBL [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef logic signed [CS_W-1:0] cs_t;
    typedef logic signed [PIX_W-1:0] pix_t;

endpackage

FILE: hdl/rbq_cordic.sv
// ----------------------------------------------------------------------------
// rbq_cordic
// Pipelined rotation-mode CORDIC giving cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
module rbq_cordic
    import rbq_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [IN_W-1:0]  angle,
    output cs_t              cos_val,
    output cs_t              sin_val
);

    cs_t                     x_reg [0:CORDIC_STAGES];
    cs_t                     y_reg [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0] z_reg [0:CORDIC_STAGES];
    logic [1:0]              q_reg [0:CORDIC_STAGES];
    cs_t                     cos_reg;
    cs_t                     sin_reg;

    logic [IN_W-1:0]         turn;
    logic signed [IN_W-1:0]  resid;

    // Split the angle into a quarter turn and a residual centered on zero.
    assign turn  = angle + IN_W'(8192);
    assign resid = $signed({2'b00, turn[13:0]}) - 16'sd8192;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= {resid, 16'd0};
            q_reg[0] <= turn[15:14];
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i+1] <= q_reg[i];
                if (!z_reg[i][ANG_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TBL[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TBL[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (q_reg[CORDIC_STAGES])
                2'd0:
                begin
                    cos_reg <= x_reg[CORDIC_STAGES];
                    sin_reg <= y_reg[CORDIC_STAGES];
                end
                2'd1:
                begin
                    cos_reg <= -y_reg[CORDIC_STAGES];
                    sin_reg <= x_reg[CORDIC_STAGES];
                end
                2'd2:
                begin
                    cos_reg <= -x_reg[CORDIC_STAGES];
                    sin_reg <= -y_reg[CORDIC_STAGES];
                end
                default:
                begin
                    cos_reg <= y_reg[CORDIC_STAGES];
                    sin_reg <= -x_reg[CORDIC_STAGES];
                end
            endcase
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

FILE: hdl/rbq_isqrt.sv
// ----------------------------------------------------------------------------
// rbq_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rbq_isqrt
    import rbq_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [SQRT_IN_W-1:0]  radicand,
    output logic [SQRT_OUT_W-1:0] root
);

    logic [SQRT_IN_W-1:0]  rem_reg  [1:SQRT_OUT_W];
    logic [SQRT_OUT_W-1:0] root_reg [1:SQRT_OUT_W];

    // The remainder always holds radicand minus the square of the partial root.
    for (genvar k = 0; k < SQRT_OUT_W; k++)
    begin : g_step
        localparam int J = SQRT_OUT_W - 1 - k;
        logic [SQRT_IN_W-1:0]  rem_in;
        logic [SQRT_OUT_W-1:0] root_in;
        logic [SQRT_IN_W-1:0]  trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
        end

        assign trial = (SQRT_IN_W'(root_in) << (J + 1)) + (SQRT_IN_W'(1) << (2 * J));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[k+1]  <= rem_in - trial;
                    root_reg[k+1] <= root_in | (SQRT_OUT_W'(1) << J);
                end
                else
                begin
                    rem_reg[k+1]  <= rem_in;
                    root_reg[k+1] <= root_in;
                end
            end
        end
    end

    assign root = root_reg[SQRT_OUT_W];

endmodule

FILE: hdl/rotated_box_to_ordered_quad_unit.sv
// ----------------------------------------------------------------------------
// rotated_box_to_ordered_quad_unit
// Turns a rotated box into four corners, ordered to best match the bounding box.
// ----------------------------------------------------------------------------
// Throughput: one box per cycle; the CORDIC and square root pipelines set the depth.
// The whole pipeline holds while a result waits at the output.
// Reset clears only the valid bits; the data path needs none.
module rotated_box_to_ordered_quad_unit
    import rbq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // center_x, center_y, box_width, box_height, box_angle
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
    output logic [95:0] m_axis_tdata
);

    localparam int LAT   = CORDIC_LAT + 30;
    localparam int CLINE = 26;

    logic adv;
    logic [LAT-1:0] vld_reg;

    assign adv           = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // Angle path.
    cs_t cos_v, sin_v;

    rbq_cordic u_cordic
    (
        .clk     (clk),
        .en      (adv),
        .angle   (s_axis_tdata[79:64]),
        .cos_val (cos_v),
        .sin_val (sin_v)
    );

    // Box geometry rides alongside the CORDIC.
    logic [63:0] geo_reg [0:CORDIC_LAT-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            geo_reg[0] <= s_axis_tdata[63:0];
            for (int n = 1; n < CORDIC_LAT; n++)
            begin
                geo_reg[n] <= geo_reg[n-1];
            end
        end
    end

    logic [IN_W-1:0] g_cx, g_cy, g_w, g_h;
    assign g_cx = geo_reg[CORDIC_LAT-1][15:0];
    assign g_cy = geo_reg[CORDIC_LAT-1][31:16];
    assign g_w  = geo_reg[CORDIC_LAT-1][47:32];
    assign g_h  = geo_reg[CORDIC_LAT-1][63:48];

    // Products.
    logic signed [PROD_W-1:0] cw_reg, sh_reg, sw_reg, ch_reg;
    logic signed [IN_W-1:0]   cx_reg, cy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cw_reg <= cos_v * $signed({1'b0, g_w});
            sh_reg <= sin_v * $signed({1'b0, g_h});
            sw_reg <= sin_v * $signed({1'b0, g_w});
            ch_reg <= cos_v * $signed({1'b0, g_h});
            cx_reg <= $signed(g_cx);
            cy_reg <= $signed(g_cy);
        end
    end

    // Corner sums in Q.(31+F).
    logic signed [ACC_W-1:0] cw_e, sh_e, sw_e, ch_e, cx_e, cy_e;
    logic signed [ACC_W-1:0] rx_reg [0:3];
    logic signed [ACC_W-1:0] ry_reg [0:3];

    assign cw_e = ACC_W'(cw_reg);
    assign sh_e = ACC_W'(sh_reg);
    assign sw_e = ACC_W'(sw_reg);
    assign ch_e = ACC_W'(ch_reg);
    assign cx_e = ACC_W'($signed({cx_reg, 31'd0}));
    assign cy_e = ACC_W'($signed({cy_reg, 31'd0}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg[0] <= -cw_e + sh_e + cx_e;
            ry_reg[0] <= -sw_e - ch_e + cy_e;
            rx_reg[1] <= cw_e + sh_e + cx_e;
            ry_reg[1] <= sw_e - ch_e + cy_e;
            rx_reg[2] <= cw_e - sh_e + cx_e;
            ry_reg[2] <= sw_e + ch_e + cy_e;
            rx_reg[3] <= -cw_e - sh_e + cx_e;
            ry_reg[3] <= -sw_e + ch_e + cy_e;
        end
    end

    // Truncate toward zero to whole pixels, then saturate.
    function automatic pix_t to_pixel(logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0]        mag;
        logic [ACC_W-1:0]        whole;
        logic signed [ACC_W:0]   p;
        mag   = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        whole = mag >> PIX_SHIFT;
        p     = v[ACC_W-1] ? -$signed({1'b0, whole}) : $signed({1'b0, whole});
        if (p < (ACC_W+1)'(PIX_MIN))
        begin
            return PIX_MIN;
        end
        else if (p > (ACC_W+1)'(PIX_MAX))
        begin
            return PIX_MAX;
        end
        return PIX_W'(p);
    endfunction

    pix_t px_reg [0:3];
    pix_t py_reg [0:3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                px_reg[i] <= to_pixel(rx_reg[i]);
                py_reg[i] <= to_pixel(ry_reg[i]);
            end
        end
    end

    // Bounding box; the corners move into the carry line here.
    pix_t xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    pix_t xmin_c, xmax_c, ymin_c, ymax_c;
    logic [8*PIX_W-1:0] quad_reg [0:CLINE-1];

    always_comb
    begin
        xmin_c = px_reg[0];
        xmax_c = px_reg[0];
        ymin_c = py_reg[0];
        ymax_c = py_reg[0];
        for (int i = 1; i < 4; i++)
        begin
            if (px_reg[i] < xmin_c) xmin_c = px_reg[i];
            if (px_reg[i] > xmax_c) xmax_c = px_reg[i];
            if (py_reg[i] < ymin_c) ymin_c = py_reg[i];
            if (py_reg[i] > ymax_c) ymax_c = py_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xmin_reg <= xmin_c;
            xmax_reg <= xmax_c;
            ymin_reg <= ymin_c;
            ymax_reg <= ymax_c;
            quad_reg[0] <= {py_reg[3], px_reg[3], py_reg[2], px_reg[2],
                            py_reg[1], px_reg[1], py_reg[0], px_reg[0]};
            for (int n = 1; n < CLINE; n++)
            begin
                quad_reg[n] <= quad_reg[n-1];
            end
        end
    end

    // Squared offsets to the box edges.
    logic [23:0] dxa_reg [0:3];
    logic [23:0] dxb_reg [0:3];
    logic [23:0] dya_reg [0:3];
    logic [23:0] dyb_reg [0:3];

    always_ff @(posedge clk)
    begin
        logic signed [PIX_W:0]   d;
        logic signed [2*PIX_W+1:0] sq;
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                d = $signed({quad_reg[0][24*i+11], quad_reg[0][24*i +: 12]})
                    - $signed({xmin_reg[PIX_W-1], xmin_reg});
                sq = d * d;
                dxa_reg[i] <= sq[23:0];
                d = $signed({quad_reg[0][24*i+11], quad_reg[0][24*i +: 12]})
                    - $signed({xmax_reg[PIX_W-1], xmax_reg});
                sq = d * d;
                dxb_reg[i] <= sq[23:0];
                d = $signed({quad_reg[0][24*i+23], quad_reg[0][24*i+12 +: 12]})
                    - $signed({ymin_reg[PIX_W-1], ymin_reg});
                sq = d * d;
                dya_reg[i] <= sq[23:0];
                d = $signed({quad_reg[0][24*i+23], quad_reg[0][24*i+12 +: 12]})
                    - $signed({ymax_reg[PIX_W-1], ymax_reg});
                sq = d * d;
                dyb_reg[i] <= sq[23:0];
            end
        end
    end

    // Distances scaled to Q.8 before the root. Index is corner*4 + box corner.
    logic [SQRT_IN_W-1:0]  rad_reg  [0:15];
    logic [SQRT_OUT_W-1:0] root_val [0:15];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rad_reg[4*i+0] <= {1'b0, 25'(dxa_reg[i]) + 25'(dya_reg[i]), 16'd0};
                rad_reg[4*i+1] <= {1'b0, 25'(dxb_reg[i]) + 25'(dya_reg[i]), 16'd0};
                rad_reg[4*i+2] <= {1'b0, 25'(dxb_reg[i]) + 25'(dyb_reg[i]), 16'd0};
                rad_reg[4*i+3] <= {1'b0, 25'(dxa_reg[i]) + 25'(dyb_reg[i]), 16'd0};
            end
        end
    end

    for (genvar m = 0; m < 16; m++)
    begin : g_root
        rbq_isqrt u_isqrt
        (
            .clk      (clk),
            .en       (adv),
            .radicand (rad_reg[m]),
            .root     (root_val[m])
        );
    end

    // Cost of each cyclic rotation.
    logic [DIST_SUM_W-1:0] cost_reg [0:3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                cost_reg[r] <= DIST_SUM_W'(root_val[4*((r+0)%4)+0])
                             + DIST_SUM_W'(root_val[4*((r+1)%4)+1])
                             + DIST_SUM_W'(root_val[4*((r+2)%4)+2])
                             + DIST_SUM_W'(root_val[4*((r+3)%4)+3]);
            end
        end
    end

    // Strict less-than keeps the earliest rotation on a tie.
    logic [1:0]            pick_c;
    logic [1:0]            pick_reg;
    logic [DIST_SUM_W-1:0] best_c;

    always_comb
    begin
        pick_c = 2'd0;
        best_c = cost_reg[0];
        for (int r = 1; r < 4; r++)
        begin
            if (cost_reg[r] < best_c)
            begin
                best_c = cost_reg[r];
                pick_c = 2'(r);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pick_reg <= pick_c;
        end
    end

    // Output register.
    logic [95:0] out_reg;
    logic [95:0] quad_last;

    assign quad_last = quad_reg[CLINE-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            case (pick_reg)
                2'd0:    out_reg <= quad_last;
                2'd1:    out_reg <= {quad_last[23:0], quad_last[95:24]};
                2'd2:    out_reg <= {quad_last[47:0], quad_last[95:48]};
                default: out_reg <= {quad_last[71:0], quad_last[95:72]};
            endcase
        end
    end

    assign m_axis_tdata = out_reg;

endmodule

FILE: tb/sv/tb_rotated_box_to_ordered_quad_unit.sv
// ----------------------------------------------------------------------------
// tb_rotated_box_to_ordered_quad_unit
// Stream testbench for the rotated box to ordered quad unit: a directed table
// of boxes and then random boxes, with every output transfer scored against a
// bit-exact predictor or a fixed expected quad under random idling on both
// sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rotated_box_to_ordered_quad_unit;

    import rbq_pkg::*;

    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM   = 500;
    localparam int N_ITEMS    = N_DIRECTED + N_RANDOM;
    localparam int DRAIN_CYC  = 100;

    typedef struct {
        logic [79:0] box;
        bit          fixed;
        logic [95:0] quad;
    } box_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;

    box_item_t   boxes [N_ITEMS];
    logic [95:0] quad_q [N_ITEMS];
    int          q_rd;
    int          n_sent;
    int          n_taken;
    int          n_quads;
    int          hold_cnt;
    bit          hold_done;
    int          errors;

    const longint ATAN_TURN [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    rotated_box_to_ordered_quad_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [79:0] pack_box(int cx, int cy, int w, int h, int ang);
        pack_box = {16'(ang), 16'(h), 16'(w), 16'(cy), 16'(cx)};
    endfunction

    function automatic logic [95:0] flat_quad(int px, int py);
        flat_quad = {4{12'(py), 12'(px)}};
    endfunction

    function automatic longint to_pixel(longint v);
        longint p;
        p = (v < 0) ? -((-v) >>> PIX_SHIFT) : (v >>> PIX_SHIFT);
        if (p < -2048)
            p = -2048;
        if (p > 2047)
            p = 2047;
        return p;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [95:0] predict_quad(logic [79:0] box);
        int              sx [4];
        int              sy [4];
        longint          cx, cy, w, h, t, z, x, y, nx, co, si;
        longint          px [4];
        longint          py [4];
        longint          bx [4];
        longint          by [4];
        longint          xmin, xmax, ymin, ymax, dx, dy;
        longint unsigned dmat [4][4];
        longint unsigned sum, best;
        int              q, pick, j;
        logic [95:0]     quad;
        sx = '{-1, 1, 1, -1};
        sy = '{-1, -1, 1, 1};
        cx = longint'($signed(box[15:0])) <<< 31;
        cy = longint'($signed(box[31:16])) <<< 31;
        w  = longint'(box[47:32]);
        h  = longint'(box[63:48]);
        // Fold the angle into a quarter turn around zero plus a quadrant.
        t  = (longint'(box[79:64]) + 8192) & 64'hFFFF;
        q  = int'(t >> 14);
        z  = ((t & 64'h3FFF) - 8192) * 65536;
        x  = 652032874;
        y  = 0;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TURN[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TURN[i];
            end
            x = nx;
        end
        case (q)
            0: begin co = x;  si = y;  end
            1: begin co = -y; si = x;  end
            2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
        endcase
        for (int i = 0; i < 4; i++)
        begin
            px[i] = to_pixel(co * (sx[i] * w) - si * (sy[i] * h) + cx);
            py[i] = to_pixel(si * (sx[i] * w) + co * (sy[i] * h) + cy);
        end
        xmin = px[0]; xmax = px[0];
        ymin = py[0]; ymax = py[0];
        for (int i = 1; i < 4; i++)
        begin
            if (px[i] < xmin) xmin = px[i];
            if (px[i] > xmax) xmax = px[i];
            if (py[i] < ymin) ymin = py[i];
            if (py[i] > ymax) ymax = py[i];
        end
        bx = '{xmin, xmax, xmax, xmin};
        by = '{ymin, ymin, ymax, ymax};
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 4; k++)
            begin
                dx = px[i] - bx[k];
                dy = py[i] - by[k];
                dmat[i][k] = int_sqrt(longint'(dx * dx + dy * dy) << 16);
            end
        best = 0;
        pick = 0;
        for (int r = 0; r < 4; r++)
        begin
            sum = 0;
            for (int k = 0; k < 4; k++)
                sum = sum + dmat[(r + k) & 3][k];
            if (r == 0 || sum < best)
            begin
                best = sum;
                pick = r;
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            j = (pick + k) & 3;
            quad[k*24 +: 12]      = 12'(px[j]);
            quad[k*24 + 12 +: 12] = 12'(py[j]);
        end
        return quad;
    endfunction

    function automatic logic [79:0] random_box();
        int cx, cy, w, h, ang;
        cx  = $urandom_range(65535);
        cy  = $urandom_range(65535);
        ang = $urandom_range(65535);
        case ($urandom_range(9))
            0, 1: begin w = $urandom_range(65535); h = $urandom_range(65535); end
            2: begin w = $urandom_range(4000); h = w; end
            3: begin w = 0; h = $urandom_range(3); end
            default: begin
                w  = $urandom_range(8000);
                h  = $urandom_range(8000);
                cx = $urandom_range(16000) - 8000;
                cy = $urandom_range(16000) - 8000;
            end
        endcase
        // Land often near eighth turns; at the odd ones the angle folding switches.
        if ($urandom_range(4) == 0)
            ang = ($urandom_range(7) * 8192 + $urandom_range(2) - 1) & 16'hFFFF;
        return pack_box(cx, cy, w, h, ang);
    endfunction

    task automatic report_mismatch(string what, logic [95:0] got, logic [95:0] want);
        $display("mismatch at result %0d: %s got %h expected %h",
                 n_quads, what, got, want);
        errors++;
    endtask

    function automatic int sender_idle(int idx);
        return (idx < N_ITEMS / 3) ? 6 : (idx < 2 * N_ITEMS / 3) ? 56 : 0;
    endfunction

    function automatic int receiver_idle(int idx);
        return (idx < N_ITEMS / 3) ? 56 : (idx < 2 * N_ITEMS / 3) ? 6 : 0;
    endfunction

    initial
    begin
        int d;
        d = 0;
        // Zero size: every corner is the centre truncated toward zero.
        boxes[d++] = '{pack_box(0, 0, 0, 0, 0), 1'b1, flat_quad(0, 0)};
        boxes[d++] = '{pack_box(32767, -32768, 0, 0, 12345), 1'b1, flat_quad(2047, -2048)};
        boxes[d++] = '{pack_box(-32768, 32767, 0, 0, 65535), 1'b1, flat_quad(-2048, 2047)};
        boxes[d++] = '{pack_box(-8, 8, 0, 0, 16384), 1'b1, flat_quad(0, 0)};
        boxes[d++] = '{pack_box(-24, 40, 0, 0, 32768), 1'b1, flat_quad(-1, 2)};
        boxes[d++] = '{pack_box(800, -15, 0, 0, 49152), 1'b1, flat_quad(50, 0)};
        boxes[d++] = '{pack_box(1600, 1600, 1600, 800, 0), 1'b0, '0};
        boxes[d++] = '{pack_box(1600, 1600, 1600, 800, 16384), 1'b0, '0};
        boxes[d++] = '{pack_box(1600, 1600, 1600, 800, 32768), 1'b0, '0};
        boxes[d++] = '{pack_box(1600, 1600, 1600, 800, 49152), 1'b0, '0};
        boxes[d++] = '{pack_box(0, 0, 1600, 800, 8191), 1'b0, '0};
        boxes[d++] = '{pack_box(0, 0, 1600, 800, 8192), 1'b0, '0};
        boxes[d++] = '{pack_box(0, 0, 1600, 800, 65535), 1'b0, '0};
        // A square at 45 degrees puts several rotations in a tie; one at zero follows.
        boxes[d++] = '{pack_box(0, 0, 1600, 1600, 8192), 1'b0, '0};
        boxes[d++] = '{pack_box(0, 0, 1600, 1600, 0), 1'b0, '0};
        // Full-range sizes and centres saturate the corners one by one; two small boxes close the table.
        boxes[d++] = '{pack_box(0, 0, 65535, 65535, 0), 1'b0, '0};
        boxes[d++] = '{pack_box(32767, 32767, 65535, 65535, 4000), 1'b0, '0};
        boxes[d++] = '{pack_box(-32768, -32768, 65535, 0, 20000), 1'b0, '0};
        boxes[d++] = '{pack_box(0, 0, 0, 65535, 40000), 1'b0, '0};
        boxes[d++] = '{pack_box(30000, -30000, 40000, 1, 9000), 1'b0, '0};
        boxes[d++] = '{pack_box(-1, -1, 1, 1, 1), 1'b0, '0};
        boxes[d++] = '{pack_box(5, -5, 33, 17, 57000), 1'b0, '0};
        for (int i = N_DIRECTED; i < N_ITEMS; i++)
            boxes[i] = '{random_box(), 1'b0, '0};
    end

    // Sender: a new box is offered only once the previous one has transferred.
    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        n_sent        = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (n_sent < N_ITEMS && $urandom_range(99) >= sender_idle(n_sent))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= boxes[n_sent].box;
                    n_sent++;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver, with one long hold-off that backs the pipeline up to its input.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_cnt      = 0;
        hold_done     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && n_quads >= 150)
            begin
                hold_done = 1'b1;
                hold_cnt  = 300;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= receiver_idle(n_sent));
        end
    end

    // Scoreboard: predict or look up on each input transfer, check on each output transfer.
    initial
    begin
        logic [95:0] want;
        n_taken = 0;
        n_quads = 0;
        q_rd    = 0;
        errors  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && s_axis_tvalid && s_axis_tready)
            begin
                quad_q[n_taken] = boxes[n_taken].fixed ? boxes[n_taken].quad
                                                       : predict_quad(s_axis_tdata);
                n_taken++;
            end
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (q_rd == n_taken)
                    report_mismatch("unexpected result", m_axis_tdata, '0);
                else
                begin
                    want = quad_q[q_rd];
                    q_rd++;
                    for (int f = 0; f < 8; f++)
                        if (m_axis_tdata[f*12 +: 12] !== want[f*12 +: 12])
                            report_mismatch($sformatf("corner%0d_%s", f / 2,
                                                      (f % 2) ? "y" : "x"),
                                            m_axis_tdata, want);
                end
                n_quads++;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (n_taken == N_ITEMS);
        wait (q_rd == n_taken);
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0 && q_rd == n_taken)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
